// ===== src/g2e_pkg.sv =====
// Shared constants, pipeline stage indexes, carry record and helper functions
// for the geodetic to ECEF converter. Depends on nothing else.
package g2e_pkg;

    localparam int ANGLE_ITERATIONS = 32;
    localparam int TAB_LEN = 64;
    localparam int ROT_STEPS = (ANGLE_ITERATIONS < TAB_LEN) ? ANGLE_ITERATIONS : TAB_LEN;

    localparam logic [63:0] ONE_Q60  = 64'd1 << 60;
    localparam logic [63:0] KINV_Q60 = 64'd700114967507363326;
    localparam logic [63:0] DEG_DIV  = 64'd1800000000;
    localparam logic [35:0] OUT_MAX  = 36'h1_FFFF_FFFF;

    localparam logic [32:0] AXIS_RESET = 33'd6378137000;
    localparam logic [36:0] ECC_RESET  = 37'd7360548640;

    localparam logic [1:0] CFG_AXIS = 2'd0;
    localparam logic [1:0] CFG_ECC  = 2'd1;

    // atan(2^-i) in Q60 from the truncated alternating series. The powers of
    // the argument are plain shifts; beyond 32 steps only the first term is left.
    function automatic logic [63:0] atan_pow2(input int i);
        logic [63:0] pw;
        logic [63:0] sum;
        logic [63:0] term;
        pw = ONE_Q60 >> i;
        sum = '0;
        for (int k = 0; k < 64; k++) begin
            if (pw != 64'd0) begin
                term = pw / 64'(2 * k + 1);
                if (k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
                pw = (i >= 32) ? 64'd0 : (pw >> (2 * i));
            end
        end
        return sum;
    endfunction

    // atan(1) from Machin's formula, 4 atan(1/5) - atan(1/239), in Q60.
    function automatic logic [63:0] atan_quarter();
        logic [63:0] pw5;
        logic [63:0] pw239;
        logic [63:0] sum5;
        logic [63:0] sum239;
        pw5 = ONE_Q60 / 64'd5;
        pw239 = ONE_Q60 / 64'd239;
        sum5 = '0;
        sum239 = '0;
        for (int k = 0; k < 64; k++) begin
            if (pw5 != 64'd0) begin
                if (k[0]) begin
                    sum5 = sum5 - pw5 / 64'(2 * k + 1);
                end else begin
                    sum5 = sum5 + pw5 / 64'(2 * k + 1);
                end
                pw5 = pw5 / 64'd25;
            end
            if (pw239 != 64'd0) begin
                if (k[0]) begin
                    sum239 = sum239 - pw239 / 64'(2 * k + 1);
                end else begin
                    sum239 = sum239 + pw239 / 64'(2 * k + 1);
                end
                pw239 = pw239 / 64'd57121;
            end
        end
        return (64'd4 * sum5) - sum239;
    endfunction

    // Entry zero is atan(1) from Machin's formula, the rest atan(2^-i).
    function automatic logic [63:0] atan_entry(input int i);
        if (i == 0) begin
            return atan_quarter();
        end
        return atan_pow2(i);
    endfunction

    localparam logic [63:0] PI_Q60   = 64'd4 * atan_entry(0);
    localparam logic [63:0] HALF_PI  = PI_Q60 >> 1;
    localparam logic [31:0] ANG_HI   = 32'(PI_Q60 / DEG_DIV);
    localparam logic [31:0] ANG_LO   = 32'(PI_Q60 % DEG_DIV);
    // Rounded-up reciprocal of the degree divisor, scaled by 2^93. The error it
    // leaves on a 62 bit dividend stays below one step of the quotient.
    localparam logic [127:0] RECIP_W =
        ((128'd1 << 93) + 128'(DEG_DIV) - 128'd1) / 128'(DEG_DIV);
    localparam logic [63:0] ANG_RECIP = RECIP_W[63:0];

    // Pipeline stage indexes of the carry line.
    localparam int S_ANG  = 4;
    localparam int S_WRAP = 5;
    localparam int S_CM   = ROT_STEPS + 6;
    localparam int S_DIV  = S_CM + 129;
    localparam int S_LAST = S_DIV + 5;
    // Edges from the accepting edge to the edge that takes the result.
    localparam int LATENCY = S_LAST + 2;

    typedef struct packed {
        logic               valid;
        logic               err;
        logic               lat_neg;
        logic               lon_neg;
        logic               wrap;
        logic signed [30:0] h;
        logic signed [63:0] alat;
        logic signed [63:0] alon;
        logic signed [63:0] slat;
        logic signed [63:0] clat;
        logic signed [63:0] slon;
        logic signed [63:0] clon;
    } t_car;

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Round a Q28 magnitude to mm, halves away from zero, then saturate.
    function automatic logic [33:0] to_mm(input logic neg, input logic [62:0] mag);
        logic [63:0] r;
        logic [33:0] s;
        r = ({1'b0, mag} + 64'd134217728) >> 28;
        s = (r > 64'(OUT_MAX)) ? 34'(OUT_MAX) : r[33:0];
        return neg ? 34'(-s) : s;
    endfunction

endpackage

// ===== src/g2e_mul.sv =====
// Two stage 64 by 64 unsigned multiplier built from four 32 bit partials.
// Stand-alone; used by the geodetic to ECEF top level.
module g2e_mul (
    input  logic         i_clk,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic [127:0] o_p
);
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [127:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p00 <= i_a[31:0] * i_b[31:0];
        r_p01 <= i_a[31:0] * i_b[63:32];
        r_p10 <= i_a[63:32] * i_b[31:0];
        r_p11 <= i_a[63:32] * i_b[63:32];
        r_p   <= {64'd0, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
               + {r_p11, 64'd0};
    end

    assign o_p = r_p;
endmodule

// ===== src/g2e_cordic_cell.sv =====
// One rotation-mode CORDIC step with registered x, y and z.
// Stand-alone; the top level chains these cells for latitude and longitude.
module g2e_cordic_cell (
    input  logic               i_clk,
    input  logic [5:0]         i_shift,
    input  logic [63:0]        i_atan,
    input  logic signed [63:0] i_x,
    input  logic signed [63:0] i_y,
    input  logic signed [63:0] i_z,
    output logic signed [63:0] o_x,
    output logic signed [63:0] o_y,
    output logic signed [63:0] o_z
);
    logic signed [63:0] dx, dy;
    logic signed [63:0] r_x, r_y, r_z;

    assign dx = i_y >>> i_shift;
    assign dy = i_x >>> i_shift;

    always_ff @(posedge i_clk) begin
        if (i_z >= 0) begin
            r_x <= i_x - dx;
            r_y <= i_y + dy;
            r_z <= i_z - signed'(i_atan);
        end else begin
            r_x <= i_x + dx;
            r_y <= i_y - dy;
            r_z <= i_z + signed'(i_atan);
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

// ===== src/g2e_sqrt_cell.sv =====
// One digit of a restoring square root: two radicand bits in, one root bit out.
// Stand-alone; the top level chains 61 of these cells.
module g2e_sqrt_cell (
    input  logic        i_clk,
    input  logic [1:0]  i_pair,
    input  logic [63:0] i_rem,
    input  logic [60:0] i_root,
    input  logic [61:0] i_v,
    output logic [63:0] o_rem,
    output logic [60:0] o_root,
    output logic [61:0] o_v
);
    logic [63:0] rem2, trial;
    logic        ge;
    logic [63:0] r_rem;
    logic [60:0] r_root;
    logic [61:0] r_v;

    assign rem2  = {i_rem[61:0], i_pair};
    assign trial = {1'b0, i_root, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge i_clk) begin
        r_rem  <= ge ? rem2 - trial : rem2;
        r_root <= {i_root[59:0], ge};
        r_v    <= i_v;
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_v    = r_v;
endmodule

// ===== src/g2e_div_cell.sv =====
// One quotient bit of a restoring divider, divisor passed along the chain.
// Stand-alone; the top level chains 64 of these cells.
module g2e_div_cell (
    input  logic        i_clk,
    input  logic [60:0] i_rem,
    input  logic [63:0] i_q,
    input  logic [60:0] i_d,
    output logic [60:0] o_rem,
    output logic [63:0] o_q,
    output logic [60:0] o_d
);
    logic [61:0] rem2, dif;
    logic        ge;
    logic [60:0] r_rem, r_d;
    logic [63:0] r_q;

    assign rem2 = {i_rem, 1'b0};
    assign ge   = rem2 >= {1'b0, i_d};
    assign dif  = rem2 - {1'b0, i_d};

    always_ff @(posedge i_clk) begin
        r_rem <= ge ? dif[60:0] : rem2[60:0];
        r_q   <= {i_q[62:0], ge};
        r_d   <= i_d;
    end

    assign o_rem = r_rem;
    assign o_q   = r_q;
    assign o_d   = r_d;
endmodule

// ===== src/geodetic_to_ecef_unit.sv =====
// Top level of the geodetic to ECEF converter: carry line, CORDIC rows,
// square root and divider chains. Uses g2e_pkg and all g2e cells.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+---------------------------------
//  command   | start / busy                | i_latitude i_longitude i_height_mm
//  result    | o_valid (one cycle strobe)  | o_ecef_x o_ecef_y o_ecef_z o_range_error
//  config    | i_cfg_valid / o_cfg_ready   | i_cfg_index i_cfg_data
//
// A point is accepted every cycle while busy is low. Most of the pipeline is
// the CORDIC rows, the 61 cell square root chain and the 64 cell divider chain.
// Reset clears the valid bits of the carry line; busy is high during reset.
// Results cannot be stalled, so the pipeline never holds.
module geodetic_to_ecef_unit
    import g2e_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [30:0] i_latitude,
    input  logic signed [31:0] i_longitude,
    input  logic signed [30:0] i_height_mm,
    output logic               o_valid,
    output logic signed [33:0] o_ecef_x,
    output logic signed [33:0] o_ecef_y,
    output logic signed [33:0] o_ecef_z,
    output logic               o_range_error,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [36:0]        i_cfg_data
);
    logic        r_live;
    logic [32:0] r_axis;
    logic [36:0] r_ecc;
    t_car        r_car [0:S_LAST];
    t_car        n_car [0:S_LAST];
    logic [31:0] r_mlat, r_mlon;
    logic [63:0] r_xlat, r_xlon;
    logic [127:0] p_qlat, p_qlon, p_s2, p_e2, p_t, p_nz, p_x, p_y, p_z;

    logic signed [63:0] xl [0:ROT_STEPS];
    logic signed [63:0] yl [0:ROT_STEPS];
    logic signed [63:0] zl [0:ROT_STEPS];
    logic signed [63:0] xo [0:ROT_STEPS];
    logic signed [63:0] yo [0:ROT_STEPS];
    logic signed [63:0] zo [0:ROT_STEPS];

    logic [63:0] sq_rem  [0:61];
    logic [60:0] sq_root [0:61];
    logic [61:0] sq_v    [0:61];
    logic [60:0] dv_rem  [0:64];
    logic [63:0] dv_q    [0:64];
    logic [60:0] dv_d    [0:64];

    logic               accept, in_err;
    logic [63:0]        sum_lat, sum_lon, dsq;
    logic signed [63:0] rh, nz, h_div, h_nz;
    logic               r_rn1, r_rn2;
    logic [62:0]        r_tmag;
    logic               r_tneg, r_nzneg;
    logic [63:0]        r_nzmag;
    logic               r_sx1, r_sx2, r_sy1, r_sy2, r_sz1, r_sz2;
    logic               r_valid, r_range_error;
    logic [33:0]        r_x, r_y, r_z;

    assign busy        = ~r_live;
    assign o_cfg_ready = r_live;
    assign accept      = start & r_live;
    assign in_err = (i_latitude > 31'sd900000000) || (i_latitude < -31'sd900000000) ||
                    (i_longitude > 32'sd1800000000) || (i_longitude < -32'sd1800000000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
            r_axis <= AXIS_RESET;
            r_ecc  <= ECC_RESET;
        end else begin
            r_live <= 1'b1;
            if (i_cfg_valid && r_live) begin
                case (i_cfg_index)
                    CFG_AXIS: r_axis <= i_cfg_data[32:0];
                    CFG_ECC:  r_ecc  <= i_cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    // Angle conversion: |v| * pi / 1.8e9 split into quotient and remainder parts.
    always_ff @(posedge i_clk) begin
        r_mlat <= i_latitude[30] ? 32'(-i_latitude) : 32'(i_latitude);
        r_mlon <= i_longitude[31] ? 32'(-i_longitude) : 32'(i_longitude);
        r_xlat <= r_mlat * ANG_LO;
        r_xlon <= r_mlon * ANG_LO;
    end

    g2e_mul u_qlat (.i_clk(i_clk), .i_a(r_xlat), .i_b(ANG_RECIP), .o_p(p_qlat));
    g2e_mul u_qlon (.i_clk(i_clk), .i_a(r_xlon), .i_b(ANG_RECIP), .o_p(p_qlon));

    assign sum_lat = r_car[S_ANG-1].alat + {29'd0, p_qlat[127:93]};
    assign sum_lon = r_car[S_ANG-1].alon + {29'd0, p_qlon[127:93]};

    always_comb begin
        n_car[0]         = '0;
        n_car[0].valid   = accept;
        n_car[0].err     = in_err;
        n_car[0].lat_neg = i_latitude[30];
        n_car[0].lon_neg = i_longitude[31];
        n_car[0].h       = i_height_mm;
        for (int k = 1; k <= S_LAST; k++) begin
            n_car[k] = r_car[k-1];
        end
        n_car[1].alat = signed'({32'd0, r_mlat} * {32'd0, ANG_HI});
        n_car[1].alon = signed'({32'd0, r_mlon} * {32'd0, ANG_HI});
        n_car[S_ANG].alat = r_car[S_ANG-1].lat_neg ? signed'(-sum_lat) : signed'(sum_lat);
        n_car[S_ANG].alon = r_car[S_ANG-1].lon_neg ? signed'(-sum_lon) : signed'(sum_lon);
        // Longitudes beyond a quarter turn are folded by pi; sine and cosine flip.
        n_car[S_WRAP].wrap = 1'b0;
        if (r_car[S_WRAP-1].alon > signed'(HALF_PI)) begin
            n_car[S_WRAP].alon = r_car[S_WRAP-1].alon - signed'(PI_Q60);
            n_car[S_WRAP].wrap = 1'b1;
        end else if (r_car[S_WRAP-1].alon < -signed'(HALF_PI)) begin
            n_car[S_WRAP].alon = r_car[S_WRAP-1].alon + signed'(PI_Q60);
            n_car[S_WRAP].wrap = 1'b1;
        end
        n_car[S_CM].slat = yl[ROT_STEPS];
        n_car[S_CM].clat = xl[ROT_STEPS];
        n_car[S_CM].slon = r_car[S_CM-1].wrap ? -yo[ROT_STEPS] : yo[ROT_STEPS];
        n_car[S_CM].clon = r_car[S_CM-1].wrap ? -xo[ROT_STEPS] : xo[ROT_STEPS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= S_LAST; k++) begin
                r_car[k].valid <= 1'b0;
            end
        end else begin
            for (int k = 0; k <= S_LAST; k++) begin
                r_car[k] <= n_car[k];
            end
        end
    end

    assign xl[0] = signed'(KINV_Q60);
    assign yl[0] = '0;
    assign zl[0] = r_car[S_WRAP].alat;
    assign xo[0] = signed'(KINV_Q60);
    assign yo[0] = '0;
    assign zo[0] = r_car[S_WRAP].alon;

    for (genvar i = 0; i < ROT_STEPS; i++) begin : g_rot
        localparam logic [63:0] AT = atan_entry(i);
        g2e_cordic_cell u_lat (
            .i_clk(i_clk), .i_shift(6'(i)), .i_atan(AT),
            .i_x(xl[i]), .i_y(yl[i]), .i_z(zl[i]),
            .o_x(xl[i+1]), .o_y(yl[i+1]), .o_z(zl[i+1])
        );
        g2e_cordic_cell u_lon (
            .i_clk(i_clk), .i_shift(6'(i)), .i_atan(AT),
            .i_x(xo[i]), .i_y(yo[i]), .i_z(zo[i]),
            .o_x(xo[i+1]), .o_y(yo[i+1]), .o_z(zo[i+1])
        );
    end

    // Radius term: 1 - e2 sin^2 lat, its root, and a / root.
    g2e_mul u_s2 (.i_clk(i_clk), .i_a(abs64(r_car[S_CM].slat)),
                  .i_b(abs64(r_car[S_CM].slat)), .o_p(p_s2));
    g2e_mul u_e2 (.i_clk(i_clk), .i_a({27'd0, r_ecc}), .i_b(p_s2[123:60]), .o_p(p_e2));

    assign dsq        = ONE_Q60 - p_e2[103:40];
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_v[0]    = dsq[61:0];

    for (genvar j = 0; j < 61; j++) begin : g_sqrt
        localparam int B = 60 - j;
        logic [1:0] pair;
        if (B >= 30) begin : g_hi
            assign pair = sq_v[j][2*B-59:2*B-60];
        end else begin : g_lo
            assign pair = 2'b00;
        end
        g2e_sqrt_cell u_cell (
            .i_clk(i_clk), .i_pair(pair),
            .i_rem(sq_rem[j]), .i_root(sq_root[j]), .i_v(sq_v[j]),
            .o_rem(sq_rem[j+1]), .o_root(sq_root[j+1]), .o_v(sq_v[j+1])
        );
    end

    assign dv_rem[0] = {4'd0, r_axis, 24'd0};
    assign dv_q[0]   = '0;
    assign dv_d[0]   = sq_root[61];

    for (genvar j = 0; j < 64; j++) begin : g_div
        g2e_div_cell u_cell (
            .i_clk(i_clk),
            .i_rem(dv_rem[j]), .i_q(dv_q[j]), .i_d(dv_d[j]),
            .o_rem(dv_rem[j+1]), .o_q(dv_q[j+1]), .o_d(dv_d[j+1])
        );
    end

    // Output products: (N + h) cos lat, ((1 - e2) N + h), then the three axes.
    assign h_div = 64'(r_car[S_DIV].h) <<< 28;
    assign h_nz  = 64'(r_car[S_DIV+2].h) <<< 28;
    assign rh    = signed'(dv_q[64]) + h_div;

    g2e_mul u_t  (.i_clk(i_clk), .i_a(abs64(rh)), .i_b(abs64(r_car[S_DIV].clat)),
                  .o_p(p_t));
    g2e_mul u_nz (.i_clk(i_clk), .i_a({23'd0, (41'd1 << 40) - {4'd0, r_ecc}}),
                  .i_b(dv_q[64]), .o_p(p_nz));

    assign nz = signed'(p_nz[103:40]) + h_nz;

    always_ff @(posedge i_clk) begin
        r_rn1   <= rh[63];
        r_rn2   <= r_rn1;
        r_tmag  <= p_t[122:60];
        r_tneg  <= r_rn2 ^ r_car[S_DIV+2].clat[63];
        r_nzmag <= abs64(nz);
        r_nzneg <= nz[63];
        r_sx1   <= r_tneg ^ r_car[S_DIV+3].clon[63];
        r_sy1   <= r_tneg ^ r_car[S_DIV+3].slon[63];
        r_sz1   <= r_nzneg ^ r_car[S_DIV+3].slat[63];
        r_sx2   <= r_sx1;
        r_sy2   <= r_sy1;
        r_sz2   <= r_sz1;
    end

    g2e_mul u_x (.i_clk(i_clk), .i_a({1'b0, r_tmag}), .i_b(abs64(r_car[S_DIV+3].clon)),
                 .o_p(p_x));
    g2e_mul u_y (.i_clk(i_clk), .i_a({1'b0, r_tmag}), .i_b(abs64(r_car[S_DIV+3].slon)),
                 .o_p(p_y));
    g2e_mul u_z (.i_clk(i_clk), .i_a(r_nzmag), .i_b(abs64(r_car[S_DIV+3].slat)),
                 .o_p(p_z));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_car[S_LAST].valid;
        end
        r_range_error <= r_car[S_LAST].err;
        if (r_car[S_LAST].err) begin
            r_x <= '0;
            r_y <= '0;
            r_z <= '0;
        end else begin
            r_x <= to_mm(r_sx2, p_x[122:60]);
            r_y <= to_mm(r_sy2, p_y[122:60]);
            r_z <= to_mm(r_sz2, p_z[122:60]);
        end
    end

    assign o_valid       = r_valid;
    assign o_range_error = r_range_error;
    assign o_ecef_x      = signed'(r_x);
    assign o_ecef_y      = signed'(r_y);
    assign o_ecef_z      = signed'(r_z);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted point did not produce a result on time");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |-> (o_ecef_x == 0 && o_ecef_y == 0 && o_ecef_z == 0))
        else $error("rejected point gave nonzero coordinates");

    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_x != 34'h2_0000_0000 && r_y != 34'h2_0000_0000 &&
                     r_z != 34'h2_0000_0000))
        else $error("coordinate beyond the saturation limit");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

endmodule
